// ===== rtl/mbrot_pkg.sv =====
// shared constants, types and the saturation function of the escape-time pixel unit
package mbrot_pkg;

  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 9;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned Q_W        = 32;
  localparam int unsigned P_W        = 64;
  localparam int unsigned SUM_W      = 38;
  localparam int unsigned ITER_W     = 8;
  localparam int unsigned MAP_SHIFT  = 29;
  localparam int unsigned RCP_W      = 52;
  localparam int unsigned RCP_SHIFT  = 52;
  localparam int unsigned QUO_SHIFT  = RCP_SHIFT - MAP_SHIFT - 1;
  localparam int unsigned IM_SHIFT   = 27;
  localparam int unsigned RE_SHIFT   = 28;

  localparam int unsigned IMG_WIDTH_DEF  = 640;
  localparam int unsigned IMG_HEIGHT_DEF = 480;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 8'd255;
  localparam logic [P_W-1:0]    ESCAPE_SQ    = 64'd1 << 58;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [P_W-1:0] prod_t;

  // clamp a widened sum to q4.28
  function automatic q_t sat_q(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(Q_MAX);
    lo = SUM_W'(Q_MIN);
    if (v > hi) begin
      sat_q = Q_MAX;
    end else if (v < lo) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/mbrot_mul.sv =====
// registered signed 32 by 32 multiplier shared by all iteration products
module mbrot_mul (
  input  logic                 clk,
  input  mbrot_pkg::q_t        op_a,
  input  mbrot_pkg::q_t        op_b,
  output mbrot_pkg::prod_t     prod
);

  mbrot_pkg::prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mbrot_pkg::P_W'(op_a) * mbrot_pkg::P_W'(op_b);
  end

  assign prod = prod_r;

endmodule

// ===== rtl/mbrot_coord_div.sv =====
// constant-reciprocal mapping of a pixel coordinate to a saturated q4.28 value
module mbrot_coord_div #(
  parameter int unsigned IMG_WIDTH  = mbrot_pkg::IMG_WIDTH_DEF,
  parameter int unsigned IMG_HEIGHT = mbrot_pkg::IMG_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             div_start,
  input  logic                             div_sel_row,
  input  logic [mbrot_pkg::POS_W-1:0]      div_pos,
  output logic                             div_done,
  output mbrot_pkg::q_t                    div_res
);

  localparam int unsigned PROD_W = mbrot_pkg::POS_W + mbrot_pkg::RCP_W;
  localparam int unsigned QUO_W  = PROD_W - mbrot_pkg::QUO_SHIFT;

  // ceil(2^52 / size) gives an exact floor for every position
  localparam logic [63:0] RCP_NUM = 64'd1 << mbrot_pkg::RCP_SHIFT;
  localparam logic [63:0] COL_DEN = 64'(IMG_WIDTH);
  localparam logic [63:0] ROW_DEN = 64'(IMG_HEIGHT);
  localparam logic [mbrot_pkg::RCP_W-1:0] RCP_COL =
    mbrot_pkg::RCP_W'((RCP_NUM + COL_DEN - 64'd1) / COL_DEN);
  localparam logic [mbrot_pkg::RCP_W-1:0] RCP_ROW =
    mbrot_pkg::RCP_W'((RCP_NUM + ROW_DEN - 64'd1) / ROW_DEN);

  localparam logic [QUO_W-1:0] MAP_OFFSET = QUO_W'(1) << mbrot_pkg::MAP_SHIFT;
  localparam logic [QUO_W-1:0] QUO_LIMIT  = MAP_OFFSET + QUO_W'(mbrot_pkg::Q_MAX);

  logic                              pend_r;
  logic                              done_r;
  logic                              sel_row_r;
  logic [mbrot_pkg::POS_W-1:0]       pos_r;
  logic [PROD_W-1:0]                 prod_r;

  logic [mbrot_pkg::RCP_W-1:0]       rcp;
  logic [QUO_W-1:0]                  quo;

  assign rcp = sel_row_r ? RCP_ROW : RCP_COL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pend_r <= div_start;
      done_r <= pend_r;
    end
    if (div_start) begin
      pos_r     <= div_pos;
      sel_row_r <= div_sel_row;
    end
    prod_r <= PROD_W'(pos_r) * PROD_W'(rcp);
  end

  // floor(pos * 2^30 / size) - 2^29, then clamp
  assign quo      = prod_r[PROD_W-1:mbrot_pkg::QUO_SHIFT];
  assign div_res  = (quo > QUO_LIMIT) ? mbrot_pkg::Q_MAX
                                      : mbrot_pkg::Q_W'(quo - MAP_OFFSET);
  assign div_done = done_r;

endmodule

// ===== rtl/mandelbrot_escape_time_pixel_top.sv =====
// escape-time pixel unit: coordinate mapping and z = z*z + c iteration sequencer
//
// A request (in_col, in_row) is taken when start is high and busy is low. Each
// coordinate is mapped to c by a constant-reciprocal multiply. The iteration
// then runs through a single registered 32x32 multiplier, stepping through
// zr*zr, zi*zi, zr*zi and update for each iteration, and busy stays high until
// the last iteration is done. The result appears on out_iter_count for exactly
// one cycle with out_valid high, the first cycle with busy low; the receiver
// cannot stall it and must take it then. A new request may be issued in that
// same cycle. max_iter is written through cfg_wr_en and cfg_wr_data; the user
// must do so only while the unit is idle, which the block does not enforce.
// A value of zero acts as one.
module mandelbrot_escape_time_pixel_top #(
  parameter int unsigned IMG_WIDTH  = mbrot_pkg::IMG_WIDTH_DEF,
  parameter int unsigned IMG_HEIGHT = mbrot_pkg::IMG_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mbrot_pkg::COL_W-1:0]       in_col,
  input  logic [mbrot_pkg::ROW_W-1:0]       in_row,
  output logic                              out_valid,
  output logic [mbrot_pkg::ITER_W-1:0]      out_iter_count,
  input  logic                              cfg_wr_en,
  input  logic [mbrot_pkg::ITER_W-1:0]      cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_RE,
    S_MAP_IM,
    S_SQ_RE,
    S_SQ_IM,
    S_CROSS,
    S_UPDATE
  } state_t;

  state_t                           state_r, state_nxt;
  logic [mbrot_pkg::ITER_W-1:0]     max_iter_r;
  logic [mbrot_pkg::ROW_W-1:0]      row_r, row_nxt;
  mbrot_pkg::q_t                    c_re_r, c_re_nxt;
  mbrot_pkg::q_t                    c_im_r, c_im_nxt;
  mbrot_pkg::q_t                    zr_r, zr_nxt;
  mbrot_pkg::q_t                    zi_r, zi_nxt;
  mbrot_pkg::prod_t                 zr2_r, zr2_nxt;
  mbrot_pkg::prod_t                 zi2_r, zi2_nxt;
  logic                             inside_r, inside_nxt;
  logic [mbrot_pkg::ITER_W-1:0]     count_r, count_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [mbrot_pkg::ITER_W-1:0]     out_count_r, out_count_nxt;

  logic                             div_start;
  logic                             div_sel_row;
  logic [mbrot_pkg::POS_W-1:0]      div_pos;
  logic                             div_done;
  mbrot_pkg::q_t                    div_res;

  mbrot_pkg::q_t                    mul_a;
  mbrot_pkg::q_t                    mul_b;
  mbrot_pkg::prod_t                 prod;

  logic [mbrot_pkg::P_W-1:0]        mag;
  mbrot_pkg::prod_t                 re_diff;
  mbrot_pkg::prod_t                 re_sh;
  mbrot_pkg::prod_t                 im_sh;
  logic signed [mbrot_pkg::SUM_W-1:0] re_sum;
  logic signed [mbrot_pkg::SUM_W-1:0] im_sum;
  logic [mbrot_pkg::ITER_W-1:0]     count_inc;

  mbrot_coord_div #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .div_start   (div_start),
    .div_sel_row (div_sel_row),
    .div_pos     (div_pos),
    .div_done    (div_done),
    .div_res     (div_res)
  );

  mbrot_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      S_SQ_IM: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      S_CROSS: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
    endcase
  end

  assign mag     = zr2_r + prod;
  assign re_diff = zr2_r - zi2_r;
  assign re_sh   = re_diff >>> mbrot_pkg::RE_SHIFT;
  assign im_sh   = prod >>> mbrot_pkg::IM_SHIFT;
  assign re_sum  = re_sh[mbrot_pkg::SUM_W-1:0]
                 + mbrot_pkg::SUM_W'(c_re_r);
  assign im_sum  = im_sh[mbrot_pkg::SUM_W-1:0]
                 + mbrot_pkg::SUM_W'(c_im_r);
  assign count_inc = count_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    c_re_nxt      = c_re_r;
    c_im_nxt      = c_im_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    zr2_nxt       = zr2_r;
    zi2_nxt       = zi2_r;
    inside_nxt    = inside_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    div_start     = 1'b0;
    div_pos       = mbrot_pkg::POS_W'(in_col);
    div_sel_row   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          div_start = 1'b1;
          row_nxt   = in_row;
          state_nxt = S_MAP_RE;
        end
      end
      S_MAP_RE: begin
        div_pos     = mbrot_pkg::POS_W'(row_r);
        div_sel_row = 1'b1;
        if (div_done) begin
          div_start = 1'b1;
          c_re_nxt  = div_res;
          state_nxt = S_MAP_IM;
        end
      end
      S_MAP_IM: begin
        if (div_done) begin
          c_im_nxt  = div_res;
          zr_nxt    = '0;
          zi_nxt    = '0;
          count_nxt = '0;
          state_nxt = S_SQ_RE;
        end
      end
      S_SQ_RE: begin
        state_nxt = S_SQ_IM;
      end
      S_SQ_IM: begin
        zr2_nxt   = prod;
        state_nxt = S_CROSS;
      end
      S_CROSS: begin
        zi2_nxt    = prod;
        inside_nxt = (mag < mbrot_pkg::ESCAPE_SQ);
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        zr_nxt    = mbrot_pkg::sat_q(re_sum);
        zi_nxt    = mbrot_pkg::sat_q(im_sum);
        count_nxt = count_inc;
        if ((count_inc >= max_iter_r) || !inside_r) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_inc;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SQ_RE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      max_iter_r  <= mbrot_pkg::MAX_ITER_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_iter_r <= cfg_wr_data;
      end
    end
    row_r       <= row_nxt;
    c_re_r      <= c_re_nxt;
    c_im_r      <= c_im_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    zr2_r       <= zr2_nxt;
    zi2_r       <= zi2_nxt;
    inside_r    <= inside_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_iter_count = out_count_r;

endmodule

// ===== dv/mandelbrot_escape_time_pixel_top_test.sv =====
// self-checking testbench for the escape-time pixel unit: directed corners, then random pixels
module mandelbrot_escape_time_pixel_top_test;

  localparam int unsigned IMG_W         = mbrot_pkg::IMG_WIDTH_DEF;
  localparam int unsigned IMG_H         = mbrot_pkg::IMG_HEIGHT_DEF;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 1200;
  localparam longint      Q_HI          = longint'(mbrot_pkg::Q_MAX);
  localparam longint      Q_LO          = longint'(mbrot_pkg::Q_MIN);
  localparam longint unsigned ESCAPE_MAG = mbrot_pkg::ESCAPE_SQ;

  logic                               clk         = 1'b0;
  logic                               rst_n       = 1'b0;
  logic                               start       = 1'b0;
  logic [mbrot_pkg::COL_W-1:0]        in_col      = '0;
  logic [mbrot_pkg::ROW_W-1:0]        in_row      = '0;
  logic                               cfg_wr_en   = 1'b0;
  logic [mbrot_pkg::ITER_W-1:0]       cfg_wr_data = '0;
  logic                               busy;
  logic                               out_valid;
  logic [mbrot_pkg::ITER_W-1:0]       out_iter_count;

  logic [mbrot_pkg::ITER_W-1:0]       iter_limit = mbrot_pkg::MAX_ITER_RST;
  logic [mbrot_pkg::ITER_W-1:0]       expected_counts[$];
  int unsigned                        fail_count   = 0;
  int unsigned                        quiet_cycles = 0;
  int unsigned                        idle_pct     = 0;

  always #5 clk = ~clk;

  mandelbrot_escape_time_pixel_top #(
    .IMG_WIDTH (IMG_W),
    .IMG_HEIGHT(IMG_H)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_col        (in_col),
    .in_row        (in_row),
    .out_valid     (out_valid),
    .out_iter_count(out_iter_count),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // floor((2*pos - size) * 2^29 / size)
  function automatic longint coord_to_q(input longint pos, input longint size);
    longint num;
    longint q;
    num = (2 * pos - size) * (longint'(1) << mbrot_pkg::MAP_SHIFT);
    q = num / size;
    if (num % size != 0 && num < 0) q = q - 1;
    return clamp_q(q);
  endfunction

  function automatic logic [mbrot_pkg::ITER_W-1:0] escape_count(
    input logic [mbrot_pkg::COL_W-1:0]  col,
    input logic [mbrot_pkg::ROW_W-1:0]  row,
    input logic [mbrot_pkg::ITER_W-1:0] limit
  );
    longint          c_re;
    longint          c_im;
    longint          zr;
    longint          zi;
    longint          zr2;
    longint          zi2;
    longint          next_re;
    longint          next_im;
    longint unsigned mag;
    int unsigned     n;
    bit              bounded;
    c_re = coord_to_q(longint'(col), longint'(IMG_W));
    c_im = coord_to_q(longint'(row), longint'(IMG_H));
    zr = 0;
    zi = 0;
    n = 0;
    do begin
      zr2 = zr * zr;
      zi2 = zi * zi;
      mag = $unsigned(zr2) + $unsigned(zi2);
      next_im = clamp_q(((zr * zi) >>> mbrot_pkg::IM_SHIFT) + c_im);
      next_re = clamp_q(((zr2 - zi2) >>> mbrot_pkg::RE_SHIFT) + c_re);
      zr = next_re;
      zi = next_im;
      n++;
      bounded = mag < ESCAPE_MAG;
    end while (n < limit && bounded);
    return n[mbrot_pkg::ITER_W-1:0];
  endfunction

  always @(posedge clk) begin : check_results
    logic [mbrot_pkg::ITER_W-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_counts.size() == 0) begin
        $error("iter_count: expected none, actual %0d", out_iter_count);
        fail_count++;
      end else begin
        want = expected_counts.pop_front();
        if (out_iter_count !== want) begin
          $error("iter_count: expected %0d, actual %0d", want, out_iter_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("mandelbrot_escape_time_pixel_top regression: fail");
      $finish;
    end
  end

  task automatic send_pixel(input logic [mbrot_pkg::COL_W-1:0] col,
                            input logic [mbrot_pkg::ROW_W-1:0] row);
    int unsigned gap;
    in_col <= col;
    in_row <= row;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    expected_counts.push_back(escape_count(col, row, iter_limit));
    gap = 0;
    // occasional long gaps so the next request lands anywhere in the work
    if (idle_pct != 0 && $urandom_range(9) == 0) gap = $urandom_range(300);
    else while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_counts.size() != 0 || busy);
  endtask

  task automatic write_limit(input logic [mbrot_pkg::ITER_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    iter_limit = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_pixel();
    if ($urandom_range(9) == 0)
      send_pixel(mbrot_pkg::COL_W'($urandom_range(1023)), mbrot_pkg::ROW_W'($urandom_range(511)));
    else
      send_pixel(mbrot_pkg::COL_W'($urandom_range(IMG_W - 1)),
                 mbrot_pkg::ROW_W'($urandom_range(IMG_H - 1)));
  endtask

  task automatic test_reset_limit();
    send_pixel(10'd320, 9'd240);
    send_pixel(10'd0, 9'd240);
    send_pixel(10'd160, 9'd240);
  endtask

  // includes coordinates past the image, which map to a c part of 2 or more
  task automatic test_field_extremes();
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd639, 9'd479);
    send_pixel(10'd640, 9'd480);
    send_pixel(10'd1023, 9'd511);
    send_pixel(10'd1023, 9'd0);
    send_pixel(10'd0, 9'd511);
    send_pixel(10'h2aa, 9'h155);
    send_pixel(10'h155, 9'h0aa);
  endtask

  // limit of zero acts as one
  task automatic test_limit_extremes();
    write_limit(8'd1);
    send_pixel(10'd320, 9'd240);
    send_pixel(10'd0, 9'd0);
    write_limit(8'd0);
    send_pixel(10'd320, 9'd240);
    send_pixel(10'd1023, 9'd511);
    write_limit(8'd2);
    send_pixel(10'd0, 9'd240);
    send_pixel(10'd320, 9'd240);
    write_limit(8'd255);
    send_pixel(10'd480, 9'd240);
  endtask

  // pauses once half way until every pending result is back
  task automatic test_random_pixels(input logic [mbrot_pkg::ITER_W-1:0] limit,
                                    input int unsigned count, input int unsigned pct);
    write_limit(limit);
    idle_pct = pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      send_random_pixel();
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_limit();
    test_field_extremes();
    test_limit_extremes();
    test_random_pixels(8'd16, 250, 0);
    test_random_pixels(mbrot_pkg::ITER_W'($urandom_range(2, 40)), 250, 61);
    test_random_pixels(8'd1, 100, 9);
    test_random_pixels(8'd255, 60, 0);
    test_random_pixels(8'd0, 60, 61);
    test_random_pixels(mbrot_pkg::ITER_W'($urandom_range(2, 64)), 250, 9);
    test_random_pixels(8'd128, 60, 61);
    test_random_pixels(8'd8, 300, 0);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_counts.size() != 0) begin
      $error("iter_count: %0d results never arrived", expected_counts.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("mandelbrot_escape_time_pixel_top regression: pass");
    end else begin
      $display("mandelbrot_escape_time_pixel_top regression: fail");
    end
    $finish;
  end

endmodule
